// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define GN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define GN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/gn3d_pkg.sv =====
// ---------------------------------------------------------------------------
// gn3d_pkg
// Types, codes and fixed widths of the octave gradient noise block.
// ---------------------------------------------------------------------------
`default_nettype none

package gn3d_pkg;

    // Item field widths.
    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 8;
    localparam int GRAD_W  = 16;
    localparam int PERM_W  = 8;
    localparam int COORD_W = 16;
    localparam int NOISE_W = 16;

    // Datapath widths.
    localparam int FRAC_W = 16;
    localparam int S_W    = 17;   // smoothstep weight, 0..65536
    localparam int OFS_W  = 17;   // signed corner offset
    localparam int PD_W   = GRAD_W + OFS_W;
    localparam int DS_W   = PD_W + 2;
    localparam int V_W    = 21;   // corner value / blend result, signed Q.16

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd2;

    localparam logic [15:0] FREQ_RESET   = 16'd3277;
    localparam logic [3:0]  LAYERS_RESET = 4'd4;
    localparam logic [8:0]  KERNEL_RESET = 9'd256;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_GRAD = 2'd0,
        FUNC_PERM = 2'd1,
        FUNC_EVAL = 2'd2
    } t_func;

endpackage

`default_nettype wire

// ===== hdl/gn3d_ram.sv =====
// ---------------------------------------------------------------------------
// gn3d_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module gn3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/gradient_noise_3d_octaves.sv =====
// ---------------------------------------------------------------------------
// gradient_noise_3d_octaves
// 3D gradient noise summed over octaves, with table loads and point evaluation.
// ---------------------------------------------------------------------------
// A gradient load is written as the item is taken, a permutation load writes its
// second copy in S_PERM2, and an evaluation runs the octave and division states.
// Throughput: one item at a time; the per-corner chain of RAM reads sets it.
// A result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears the controller and loads register
// defaults; the table RAMs are not cleared and hold garbage until written.
`default_nettype none

module gradient_noise_3d_octaves #(
    parameter int TABLE_SIZE = 256,
    parameter int MAX_LAYERS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [gn3d_pkg::FUNC_W-1:0]       i_func,
    input  logic [gn3d_pkg::IDX_W-1:0]        i_table_index,
    input  logic signed [gn3d_pkg::GRAD_W-1:0] i_grad_x,
    input  logic signed [gn3d_pkg::GRAD_W-1:0] i_grad_y,
    input  logic signed [gn3d_pkg::GRAD_W-1:0] i_grad_z,
    input  logic [gn3d_pkg::PERM_W-1:0]       i_perm_value,
    input  logic [gn3d_pkg::COORD_W-1:0]      i_coord_x,
    input  logic [gn3d_pkg::COORD_W-1:0]      i_coord_y,
    input  logic [gn3d_pkg::COORD_W-1:0]      i_coord_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [gn3d_pkg::NOISE_W-1:0]      o_noise_value,
    input  logic                              i_cfg_we,
    input  logic [gn3d_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gn3d_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import gn3d_pkg::*;

    // Index widths. The lattice index lives below the kernel size, the
    // permutation table is twice the gradient table.
    localparam int KS_W  = $clog2(TABLE_SIZE + 1);
    localparam int GA_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int PA_W  = $clog2(2 * TABLE_SIZE);
    localparam int MW    = $clog2(2 * TABLE_SIZE + 256);
    localparam int LY_W  = $clog2(MAX_LAYERS + 1);
    localparam int ACC_W = MAX_LAYERS + 22;
    localparam int DEN_W = MAX_LAYERS + 2;
    localparam int DSH_W = DEN_W + 16;
    localparam int BP_W  = V_W + S_W + 2;
    localparam int MOD_K = 7;
    // Subtract steps for the two constant remainders of the hash.
    localparam int STEPS_P = (MW - $clog2(2 * TABLE_SIZE) + 1 > 1) ?
                             (MW - $clog2(2 * TABLE_SIZE) + 1) : 1;
    localparam int STEPS_G = (9 - $clog2(TABLE_SIZE) > 1) ? (9 - $clog2(TABLE_SIZE)) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_PERM2, S_INIT, S_SM1, S_SM2,
        S_H0, S_H1, S_H2, S_H3, S_H4, S_H5,
        S_BLX, S_BLY, S_BLZ, S_DIVS, S_DIV, S_OUT
    } t_state;

    // Remainder by a constant through a short chain of conditional subtracts.
    function automatic logic [MW-1:0] mod_const(input logic [MW-1:0] v, input int m,
                                                input int steps);
        logic [MW-1:0] r;
        r = v;
        for (int k = MOD_K; k >= 0; k--) begin
            if (k < steps && 32'(r) >= (m << k)) begin
                r = r - MW'(m << k);
            end
        end
        return r;
    endfunction

    // Configuration registers.
    logic [15:0] r_freq;
    logic [3:0]  r_layers;
    logic [8:0]  r_kernel;

    // Controller and datapath registers.
    t_state                   r_state;
    logic [PA_W-1:0]          r_pw_addr;
    logic [PERM_W-1:0]        r_pv;
    logic [KS_W-1:0]          r_r   [3];
    logic [15:0]              r_int [3];
    logic [FRAC_W-1:0]        r_t   [3];
    logic [31:0]              r_tt  [3];
    logic [S_W-1:0]           r_s   [3];
    logic signed [PD_W-1:0]   r_pd  [3];
    logic [3:0]               r_cnt;
    logic [2:0]               r_k;
    logic signed [V_W-1:0]    r_v0, r_vc, r_bx, r_xc, r_by, r_yc;
    logic signed [ACC_W-1:0]  r_acc;
    logic [LY_W-1:0]          r_layer;
    logic [ACC_W-1:0]         r_num;
    logic [DSH_W-1:0]         r_dsh;
    logic [4:0]               r_dcnt;
    logic [NOISE_W-1:0]       r_q;
    logic                     r_o_valid;
    logic [NOISE_W-1:0]       r_noise;

    // Combinational signals.
    logic                     accept;
    logic                     in_range;
    logic [31:0]              ti32;
    logic [KS_W-1:0]          ks;
    logic [LY_W-1:0]          nl;
    logic [ACC_W-1:0]         wsum;
    logic [DEN_W-1:0]         den;
    logic [COORD_W-1:0]       coord [3];
    logic [31:0]              cprod [3];
    logic [KS_W-1:0]          r1    [3];
    logic [KS_W-1:0]          step_int [3];
    logic [KS_W-1:0]          step_frac [3];
    logic [31:0]              sq    [3];
    logic [17:0]              sm_m  [3];
    logic [50:0]              sm_p  [3];
    logic [KS_W-1:0]          idx_x, idx_y, idx_z;
    logic [MW-1:0]            hy, hz, hg;
    logic                     grad_we, perm_we;
    logic [GA_W-1:0]          grad_waddr, grad_raddr;
    logic [PA_W-1:0]          perm_waddr, perm_raddr;
    logic [PERM_W-1:0]        perm_wdata, perm_rd;
    logic [3*GRAD_W-1:0]      grad_rd;
    logic signed [GRAD_W-1:0] g   [3];
    logic signed [OFS_W-1:0]  ofs [3];
    logic signed [PD_W-1:0]   pd  [3];
    logic signed [DS_W-1:0]   dsum;
    logic signed [V_W-1:0]    dv;
    logic signed [V_W-1:0]    bl_a, bl_b, bl_res;
    logic [S_W-1:0]           bl_s;
    logic signed [V_W:0]      bdiff;
    logic signed [S_W:0]      bs;
    logic signed [BP_W-1:0]   bprod, bround;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     div_ge;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign ti32     = 32'(i_table_index);
    assign in_range = (ti32 < TABLE_SIZE);

    // Kernel size and octave count in effect, clamped to the supported range.
    always_comb begin
        if (r_kernel < 9'd2) begin
            ks = KS_W'(2);
        end else if (32'(r_kernel) > TABLE_SIZE) begin
            ks = KS_W'(TABLE_SIZE);
        end else begin
            ks = KS_W'(r_kernel);
        end
        if (r_layers == 4'd0) begin
            nl = LY_W'(1);
        end else if (32'(r_layers) > MAX_LAYERS) begin
            nl = LY_W'(MAX_LAYERS);
        end else begin
            nl = LY_W'(r_layers);
        end
    end

    // Sum of octave weights, and twice that as the divisor.
    assign wsum = (ACC_W'(1) << nl) - ACC_W'(1);
    assign den  = DEN_W'(wsum) << 1;

    assign coord[0] = i_coord_x;
    assign coord[1] = i_coord_y;
    assign coord[2] = i_coord_z;

    // Per-axis arithmetic. The lattice index of each octave follows from the
    // previous one by doubling and shifting in the next fraction bit, so the
    // remainder by the kernel size needs one compare and subtract per bit.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [KS_W:0] vi, vf, inc;
            cprod[c] = coord[c] * r_freq;
            inc      = {1'b0, r_r[c]} + 1'b1;
            r1[c]    = (inc == {1'b0, ks}) ? '0 : KS_W'(inc);
            vi       = {r_r[c], r_int[c][15]};
            vf       = {r_r[c], r_t[c][FRAC_W-1]};
            step_int[c]  = (vi >= {1'b0, ks}) ? KS_W'(vi - {1'b0, ks}) : KS_W'(vi);
            step_frac[c] = (vf >= {1'b0, ks}) ? KS_W'(vf - {1'b0, ks}) : KS_W'(vf);
            sq[c]    = r_t[c] * r_t[c];
            sm_m[c]  = 18'd196608 - {1'b0, r_t[c], 1'b0};
            sm_p[c]  = r_tt[c] * sm_m[c];
        end
    end

    // Hash chain: corner bit k selects the lower or upper lattice index.
    assign idx_x = r_k[0] ? r1[0] : r_r[0];
    assign idx_y = r_k[1] ? r1[1] : r_r[1];
    assign idx_z = r_k[2] ? r1[2] : r_r[2];
    assign hy    = mod_const(MW'(perm_rd) + MW'(idx_y), 2 * TABLE_SIZE, STEPS_P);
    assign hz    = mod_const(MW'(perm_rd) + MW'(idx_z), 2 * TABLE_SIZE, STEPS_P);
    assign hg    = mod_const(MW'(perm_rd), TABLE_SIZE, STEPS_G);

    always_comb begin
        unique case (r_state)
            S_H1:    perm_raddr = hy[PA_W-1:0];
            S_H2:    perm_raddr = hz[PA_W-1:0];
            default: perm_raddr = PA_W'(idx_x);
        endcase
    end
    assign grad_raddr = hg[GA_W-1:0];

    // Table writes: gradient loads and the first permutation copy go straight
    // in when the item is taken; the second copy follows from S_PERM2.
    assign grad_we    = accept && (i_func == FUNC_GRAD) && in_range;
    assign grad_waddr = ti32[GA_W-1:0];
    assign perm_we    = (accept && (i_func == FUNC_PERM) && in_range) ||
                        (r_state == S_PERM2);
    assign perm_waddr = (r_state == S_PERM2) ? r_pw_addr : ti32[PA_W-1:0];
    assign perm_wdata = (r_state == S_PERM2) ? r_pv : i_perm_value;

    gn3d_ram #(
        .WIDTH (3 * GRAD_W),
        .DEPTH (TABLE_SIZE)
    ) u_grad_ram (
        .i_clk   (i_clk),
        .i_we    (grad_we),
        .i_waddr (grad_waddr),
        .i_wdata ({i_grad_x, i_grad_y, i_grad_z}),
        .i_raddr (grad_raddr),
        .o_rdata (grad_rd)
    );

    gn3d_ram #(
        .WIDTH (PERM_W),
        .DEPTH (2 * TABLE_SIZE)
    ) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_waddr (perm_waddr),
        .i_wdata (perm_wdata),
        .i_raddr (perm_raddr),
        .o_rdata (perm_rd)
    );

    // Dot product of the corner gradient with the offset to the point. An
    // offset toward the upper corner is t - 1, which in 17 bits is {1, t}.
    assign g[0] = $signed(grad_rd[3*GRAD_W-1:2*GRAD_W]);
    assign g[1] = $signed(grad_rd[2*GRAD_W-1:GRAD_W]);
    assign g[2] = $signed(grad_rd[GRAD_W-1:0]);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ofs[c] = $signed({r_k[c], r_t[c]});
            pd[c]  = g[c] * ofs[c];
        end
        dsum = r_pd[0] + r_pd[1] + r_pd[2] + DS_W'(8192);
        dv   = V_W'(dsum >>> 14);
    end

    // Shared blend unit: a + round((b - a) * s / 2^16).
    always_comb begin
        unique case (r_state)
            S_BLX: begin
                bl_a = r_v0;
                bl_b = r_vc;
                bl_s = r_s[0];
            end
            S_BLY: begin
                bl_a = r_bx;
                bl_b = r_xc;
                bl_s = r_s[1];
            end
            default: begin
                bl_a = r_by;
                bl_b = r_yc;
                bl_s = r_s[2];
            end
        endcase
        bdiff    = bl_b - bl_a;
        bs       = $signed({1'b0, bl_s});
        bprod    = bdiff * bs;
        bround   = bprod + BP_W'(32768);
        bl_res   = V_W'(bl_a + (bround >>> 16));
        // Weighted octave sum in Horner form: each new octave doubles the
        // weight of everything before it.
        acc_next = (r_acc <<< 1) + ACC_W'(bl_res) + ACC_W'(65536);
    end

    assign div_ge = (r_num >= ACC_W'(r_dsh));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq   <= FREQ_RESET;
            r_layers <= LAYERS_RESET;
            r_kernel <= KERNEL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FREQ:   r_freq   <= i_cfg_data;
                CFG_LAYERS: r_layers <= i_cfg_data[3:0];
                CFG_KERNEL: r_kernel <= i_cfg_data[8:0];
                default:    ;
            endcase
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // The output register empties when its item is taken, unless a
            // new result replaces it in the same cycle.
            if (r_o_valid && !i_stall && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_func)
                            FUNC_PERM: begin
                                if (in_range) begin
                                    r_pw_addr <= ti32[PA_W-1:0] + PA_W'(ks);
                                    r_pv      <= i_perm_value;
                                    r_state   <= S_PERM2;
                                end
                            end
                            FUNC_EVAL: begin
                                for (int c = 0; c < 3; c++) begin
                                    r_int[c] <= cprod[c][31:16];
                                    r_t[c]   <= cprod[c][15:0];
                                    r_r[c]   <= '0;
                                end
                                r_cnt   <= 4'd15;
                                r_layer <= '0;
                                r_acc   <= '0;
                                r_state <= S_INIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PERM2: begin
                    r_state <= S_IDLE;
                end
                S_INIT: begin
                    // Integer part of octave zero, reduced one bit a cycle.
                    for (int c = 0; c < 3; c++) begin
                        r_r[c]   <= step_int[c];
                        r_int[c] <= {r_int[c][14:0], 1'b0};
                    end
                    if (r_cnt == 4'd0) begin
                        r_state <= S_SM1;
                    end else begin
                        r_cnt <= r_cnt - 4'd1;
                    end
                end
                S_SM1: begin
                    for (int c = 0; c < 3; c++) begin
                        r_tt[c] <= sq[c];
                    end
                    r_state <= S_SM2;
                end
                S_SM2: begin
                    for (int c = 0; c < 3; c++) begin
                        r_s[c] <= S_W'((sm_p[c] + 51'h80000000) >> 32);
                    end
                    r_k     <= 3'd0;
                    r_state <= S_H0;
                end
                S_H0: r_state <= S_H1;
                S_H1: r_state <= S_H2;
                S_H2: r_state <= S_H3;
                S_H3: r_state <= S_H4;
                S_H4: begin
                    for (int c = 0; c < 3; c++) begin
                        r_pd[c] <= pd[c];
                    end
                    r_state <= S_H5;
                end
                S_H5: begin
                    if (!r_k[0]) begin
                        r_v0    <= dv;
                        r_k     <= r_k + 3'd1;
                        r_state <= S_H0;
                    end else begin
                        r_vc    <= dv;
                        r_state <= S_BLX;
                    end
                end
                S_BLX: begin
                    if (!r_k[1]) begin
                        r_bx    <= bl_res;
                        r_k     <= r_k + 3'd1;
                        r_state <= S_H0;
                    end else begin
                        r_xc    <= bl_res;
                        r_state <= S_BLY;
                    end
                end
                S_BLY: begin
                    if (!r_k[2]) begin
                        r_by    <= bl_res;
                        r_k     <= r_k + 3'd1;
                        r_state <= S_H0;
                    end else begin
                        r_yc    <= bl_res;
                        r_state <= S_BLZ;
                    end
                end
                S_BLZ: begin
                    r_acc <= acc_next;
                    if (r_layer == nl - LY_W'(1)) begin
                        r_state <= S_DIVS;
                    end else begin
                        // Next octave doubles the position.
                        for (int c = 0; c < 3; c++) begin
                            r_r[c] <= step_frac[c];
                            r_t[c] <= {r_t[c][FRAC_W-2:0], 1'b0};
                        end
                        r_layer <= r_layer + LY_W'(1);
                        r_state <= S_SM1;
                    end
                end
                S_DIVS: begin
                    r_q <= '0;
                    if (r_acc <= 0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_num   <= ACC_W'(r_acc) + wsum;
                        r_dsh   <= DSH_W'(den) << 16;
                        r_dcnt  <= 5'd16;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Restoring division; the first step only detects a
                    // quotient too large for the output and saturates.
                    r_dsh <= r_dsh >> 1;
                    if (r_dcnt == 5'd16) begin
                        if (div_ge) begin
                            r_q     <= '1;
                            r_state <= S_OUT;
                        end
                        r_dcnt <= r_dcnt - 5'd1;
                    end else begin
                        if (div_ge) begin
                            r_num <= r_num - ACC_W'(r_dsh);
                        end
                        r_q <= {r_q[NOISE_W-2:0], div_ge};
                        if (r_dcnt == 5'd0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_dcnt <= r_dcnt - 5'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_noise   <= r_q;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_noise_value = r_noise;

endmodule

`default_nettype wire

// ===== hdl/gn3d_checker.sv =====
// ---------------------------------------------------------------------------
// gn3d_checker
// Port-level assertions for the octave gradient noise block.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gn3d_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [gn3d_pkg::FUNC_W-1:0] i_func,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [gn3d_pkg::NOISE_W-1:0] o_noise_value
);

    import gn3d_pkg::*;

    `GN_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `GN_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_noise_value))
    // An accepted evaluation makes the block busy.
    `GN_ASSERT_NXT(a_eval_busy, i_clk, i_rst_n, i_valid && !o_stall && i_func == FUNC_EVAL, o_stall)
    // Loads and unknown codes never produce a result.
    `GN_ASSERT_NXT(a_load_quiet, i_clk, i_rst_n, i_valid && !o_stall && i_func != FUNC_EVAL && !o_valid, !o_valid)

endmodule

bind gradient_noise_3d_octaves gn3d_checker u_gn3d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_func        (i_func),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_noise_value (o_noise_value)
);

`default_nettype wire

// ===== tb/gradient_noise_3d_octaves_chk.sv =====
// ---------------------------------------------------------------------------
// gradient_noise_3d_octaves_chk
// Watches the item and result channels of the octave noise block, keeps its
// own copy of the tables and registers, predicts every noise value and
// compares each delivered result with the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module gradient_noise_3d_octaves_chk
    import gn3d_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_in_stall,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic [IDX_W-1:0]           i_table_index,
    input  logic signed [GRAD_W-1:0]   i_grad_x,
    input  logic signed [GRAD_W-1:0]   i_grad_y,
    input  logic signed [GRAD_W-1:0]   i_grad_z,
    input  logic [PERM_W-1:0]          i_perm_value,
    input  logic [COORD_W-1:0]         i_coord_x,
    input  logic [COORD_W-1:0]         i_coord_y,
    input  logic [COORD_W-1:0]         i_coord_z,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [NOISE_W-1:0]         i_noise_value,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL = 256;
    localparam int LMAX = 8;

    shortint            grad_mem [TBL][3];
    byte unsigned       perm_mem [2*TBL];
    logic [15:0]        freq_q;
    logic [3:0]         layers_q;
    logic [8:0]         kernel_q;
    logic [NOISE_W-1:0] noise_expected_q [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_errors++;
    endtask

    function automatic int unsigned kernel_eff();
        int unsigned k;
        k = kernel_q;
        if (k < 2) k = 2;
        if (k > TBL) k = TBL;
        return k;
    endfunction

    function automatic longint smoothstep_q16(input longint unsigned t);
        longint unsigned p;
        p = t * t * (64'd196608 - 2 * t);
        return longint'((p + 64'h8000_0000) >> 32);
    endfunction

    function automatic longint lerp_q16(input longint a, input longint b, input longint s);
        return a + (((b - a) * s + 32768) >>> 16);
    endfunction

    function automatic int unsigned corner_hash(input int unsigned x, input int unsigned y,
                                                input int unsigned z);
        int unsigned a, b, c;
        a = perm_mem[x % (2*TBL)];
        b = perm_mem[(a + y) % (2*TBL)];
        c = perm_mem[(b + z) % (2*TBL)];
        return c % TBL;
    endfunction

    function automatic longint octave_q16(input longint unsigned c [3], input int sh,
                                          input int unsigned ks);
        longint unsigned p;
        int unsigned     r0 [3];
        int unsigned     r1 [3];
        longint          t [3];
        longint          s [3];
        longint          v [8];
        longint          dsum, ox, oy, oz, a, b, cc, d, e, f;
        int unsigned     g;
        for (int i = 0; i < 3; i++) begin
            p = (c[i] * longint'(freq_q)) << sh;
            r0[i] = (p >> 16) % ks;
            r1[i] = (r0[i] + 1) % ks;
            t[i] = p & 64'hFFFF;
            s[i] = smoothstep_q16(t[i]);
        end
        // Corner n is ordered z, y, x from the top bit down.
        for (int n = 0; n < 8; n++) begin
            g = corner_hash((n & 1) ? r1[0] : r0[0], (n & 2) ? r1[1] : r0[1],
                            (n & 4) ? r1[2] : r0[2]);
            ox = t[0] - ((n & 1) ? 65536 : 0);
            oy = t[1] - ((n & 2) ? 65536 : 0);
            oz = t[2] - ((n & 4) ? 65536 : 0);
            dsum = longint'(grad_mem[g][0]) * ox + longint'(grad_mem[g][1]) * oy
                 + longint'(grad_mem[g][2]) * oz;
            v[n] = (dsum + 8192) >>> 14;
        end
        a  = lerp_q16(v[0], v[1], s[0]);
        b  = lerp_q16(v[2], v[3], s[0]);
        cc = lerp_q16(v[4], v[5], s[0]);
        d  = lerp_q16(v[6], v[7], s[0]);
        e  = lerp_q16(a, b, s[1]);
        f  = lerp_q16(cc, d, s[1]);
        return lerp_q16(e, f, s[2]);
    endfunction

    function automatic logic [NOISE_W-1:0] fbm_noise(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y,
                                                     input logic [COORD_W-1:0] z);
        longint unsigned c [3];
        int unsigned     nl, ks;
        longint          acc, w, q;
        c[0] = x; c[1] = y; c[2] = z;
        ks = kernel_eff();
        nl = layers_q;
        if (nl < 1) nl = 1;
        if (nl > LMAX) nl = LMAX;
        acc = 0;
        for (int i = 0; i < nl; i++)
            acc += (octave_q16(c, i, ks) + 65536) * (longint'(1) << (nl - 1 - i));
        w = (longint'(1) << nl) - 1;
        if (acc <= 0) q = 0;
        else begin
            q = (acc + w) / (2 * w);
            if (q > 65535) q = 65535;
        end
        return q[NOISE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            freq_q   <= FREQ_RESET;
            layers_q <= LAYERS_RESET;
            kernel_q <= KERNEL_RESET;
            noise_expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FREQ:   freq_q   <= i_cfg_data;
                    CFG_LAYERS: layers_q <= i_cfg_data[3:0];
                    CFG_KERNEL: kernel_q <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall) begin
                case (i_func)
                    FUNC_GRAD: begin
                        grad_mem[i_table_index][0] = i_grad_x;
                        grad_mem[i_table_index][1] = i_grad_y;
                        grad_mem[i_table_index][2] = i_grad_z;
                    end
                    FUNC_PERM: begin
                        perm_mem[i_table_index] = i_perm_value;
                        perm_mem[i_table_index + kernel_eff()] = i_perm_value;
                    end
                    FUNC_EVAL: noise_expected_q.push_back(fbm_noise(i_coord_x, i_coord_y,
                                                                    i_coord_z));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (noise_expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected noise_value %0d", i_noise_value));
                else if (noise_expected_q[0] !== i_noise_value) begin
                    report_mismatch($sformatf("noise_value %0d, expected %0d",
                                              i_noise_value, noise_expected_q[0]));
                    void'(noise_expected_q.pop_front());
                end else
                    void'(noise_expected_q.pop_front());
            end
            o_pending <= noise_expected_q.size();
        end
    end

    initial begin
        o_errors  = 0;
        o_results = 0;
        o_pending = 0;
    end

endmodule

`default_nettype wire

// ===== tb/gradient_noise_3d_octaves_tb.sv =====
// ---------------------------------------------------------------------------
// gradient_noise_3d_octaves_tb
// Fills both tables, evaluates directed corner points under extreme register
// settings, then runs random table loads and evaluations under three idling
// profiles and a long result hold-off, with a checker predicting each result.
// ---------------------------------------------------------------------------
`default_nettype none

module gradient_noise_3d_octaves_tb;
    import gn3d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Settle time used before register writes and at the end of the run.
    localparam int SETTLE = 600;
    localparam int HOLD_CYCLES = 1200;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [FUNC_W-1:0]        i_func;
    logic [IDX_W-1:0]         i_table_index;
    logic signed [GRAD_W-1:0] i_grad_x, i_grad_y, i_grad_z;
    logic [PERM_W-1:0]        i_perm_value;
    logic [COORD_W-1:0]       i_coord_x, i_coord_y, i_coord_z;
    logic                     o_valid;
    logic                     i_stall;
    logic [NOISE_W-1:0]       o_noise_value;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;

    int errors, pending, results;
    int tx_idle_pct, rx_idle_pct;
    bit hold_req;
    int items_sent;

    gradient_noise_3d_octaves u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_table_index(i_table_index),
        .i_grad_x(i_grad_x), .i_grad_y(i_grad_y), .i_grad_z(i_grad_z),
        .i_perm_value(i_perm_value),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .o_valid(o_valid), .i_stall(i_stall), .o_noise_value(o_noise_value),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    gradient_noise_3d_octaves_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_stall(o_stall),
        .i_func(i_func), .i_table_index(i_table_index),
        .i_grad_x(i_grad_x), .i_grad_y(i_grad_y), .i_grad_z(i_grad_z),
        .i_perm_value(i_perm_value),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_noise_value(o_noise_value),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // Result side: random stalls, or one long hold-off on request so that the
    // block fills its output register, takes one more item and stalls input.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Offers one item and returns in the time step at which it was accepted,
    // with valid still high; the next call or settle_block follows at once.
    task automatic send_item(input t_func f, input logic [IDX_W-1:0] idx,
                             input logic [GRAD_W-1:0] gx, input logic [GRAD_W-1:0] gy,
                             input logic [GRAD_W-1:0] gz, input logic [PERM_W-1:0] pv,
                             input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                             input logic [COORD_W-1:0] cz);
        logic stall_seen;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_table_index <= idx;
        i_grad_x <= gx; i_grad_y <= gy; i_grad_z <= gz;
        i_perm_value <= pv;
        i_coord_x <= cx; i_coord_y <= cy; i_coord_z <= cz;
        // Stall only changes at the rising edge, so the falling edge gives a
        // stable sample of what the next edge will see.
        forever begin
            @(negedge i_clk);
            stall_seen = o_stall;
            @(posedge i_clk);
            if (!stall_seen) break;
        end
        items_sent++;
    endtask

    function automatic logic [GRAD_W-1:0] rand_grad();
        return GRAD_W'($signed($urandom_range(32768)) - 16384);
    endfunction

    task automatic send_eval(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                             input logic [COORD_W-1:0] cz);
        send_item(FUNC_EVAL, IDX_W'($urandom), rand_grad(), rand_grad(), rand_grad(),
                  PERM_W'($urandom), cx, cy, cz);
    endtask

    // Waits for every predicted result, then for the block to finish any
    // load still in flight, before the registers may change.
    task automatic settle_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] freq, input logic [15:0] layers,
                              input logic [15:0] kernel);
        settle_block();
        i_cfg_we <= 1'b1; i_cfg_index <= CFG_FREQ; i_cfg_data <= freq;
        @(posedge i_clk);
        i_cfg_index <= CFG_LAYERS; i_cfg_data <= layers;
        @(posedge i_clk);
        i_cfg_index <= CFG_KERNEL; i_cfg_data <= kernel;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random register setting, weighted toward the extremes and toward few
    // octaves so that the run stays short.
    task automatic random_regs();
        logic [15:0] fr, ly, ks;
        case ($urandom_range(3))
            0: fr = 16'd0;
            1: fr = 16'hFFFF;
            default: fr = 16'($urandom);
        endcase
        case ($urandom_range(5))
            0: ly = 16'd0;
            1: ly = 16'd8;
            2: ly = 16'($urandom_range(15, 9));
            default: ly = 16'($urandom_range(4, 1));
        endcase
        case ($urandom_range(4))
            0: ks = 16'($urandom_range(2));
            1: ks = 16'd256;
            2: ks = 16'($urandom_range(511, 257));
            default: ks = 16'($urandom_range(255, 3));
        endcase
        write_regs(fr, ly, ks);
    endtask

    // Mostly evaluations; loads refresh entries that are already written,
    // so no read ever reaches a never-written entry.
    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 62) begin
            case ($urandom_range(3))
                0: send_eval($urandom_range(1) ? 16'hFFFF : 16'h0000, COORD_W'($urandom),
                             COORD_W'($urandom));
                default: send_eval(COORD_W'($urandom), COORD_W'($urandom),
                                   COORD_W'($urandom));
            endcase
        end else if (r < 80)
            send_item(FUNC_GRAD, IDX_W'($urandom), rand_grad(), rand_grad(), rand_grad(),
                      PERM_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom));
        else if (r < 95)
            send_item(FUNC_PERM, IDX_W'($urandom), rand_grad(), rand_grad(), rand_grad(),
                      PERM_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom));
        else
            send_item(t_func'(2'd3), IDX_W'($urandom), rand_grad(), rand_grad(), rand_grad(),
                      PERM_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FUNC_GRAD;
        i_table_index = '0;
        i_grad_x = '0; i_grad_y = '0; i_grad_z = '0;
        i_perm_value = '0;
        i_coord_x = '0; i_coord_y = '0; i_coord_z = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_FREQ;
        i_cfg_data = '0;
        tx_idle_pct = 17;
        rx_idle_pct = 58;
        hold_req = 1'b0;
        items_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every table entry with the full kernel so that each
        // permutation load covers both halves. Entries 0 and 1 carry the
        // gradient extremes.
        for (int i = 0; i < 256; i++) begin
            if (i == 0)
                send_item(FUNC_GRAD, IDX_W'(i), 16'sd16384, -16'sd16384, 16'sd16384,
                          0, 0, 0, 0);
            else if (i == 1)
                send_item(FUNC_GRAD, IDX_W'(i), -16'sd16384, 16'sd16384, -16'sd16384,
                          0, 0, 0, 0);
            else
                send_item(FUNC_GRAD, IDX_W'(i), rand_grad(), rand_grad(), rand_grad(),
                          0, 0, 0, 0);
        end
        for (int i = 0; i < 256; i++)
            send_item(FUNC_PERM, IDX_W'(i), 0, 0, 0, (i == 0) ? 8'd255 : 8'($urandom),
                      0, 0, 0);

        // Directed: reset registers first, then extreme settings, including
        // zero frequency and out-of-range layer and kernel values.
        send_eval(16'h0000, 16'h0000, 16'h0000);
        send_eval(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_eval(16'hFFFF, 16'h0000, 16'h8000);
        send_item(t_func'(2'd3), 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_regs(16'd0, 16'd1, 16'd256);
        send_eval(16'h1234, 16'hFFFF, 16'h0001);
        write_regs(16'hFFFF, 16'd8, 16'd2);
        send_eval(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_eval(16'h0001, 16'h0000, 16'h7FFF);
        write_regs(16'd1, 16'd0, 16'd0);
        send_eval(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(FUNC_PERM, 8'hFF, 0, 0, 0, 8'hFF, 0, 0, 0);
        send_eval(16'hABCD, 16'h5432, 16'hFFFF);
        write_regs(16'h8000, 16'd15, 16'd511);
        send_eval(16'hFFFF, 16'h0000, 16'hFFFF);
        send_item(FUNC_PERM, 8'h00, 0, 0, 0, 8'h00, 0, 0, 0);
        send_eval(16'h0003, 16'h0007, 16'h000F);
        write_regs(16'd3277, 16'd2, 16'd1);
        send_eval(16'h00FF, 16'hFF00, 16'h0F0F);
        send_item(FUNC_GRAD, 8'hFF, 16'sd16384, 16'sd16384, -16'sd16384, 0, 0, 0, 0);
        send_eval(16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Random part: three idling profiles, four register settings each.
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 58 : 0;
            rx_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 17 : 0;
            for (int s = 0; s < 4; s++) begin
                random_regs();
                for (int n = 0; n < 90; n++) begin
                    if (s == 1 && n == 20) hold_req = 1'b1;
                    random_item();
                end
            end
        end

        settle_block();
        $display("Sent %0d items (table loads, evaluations, ignored codes); checked %0d",
                 items_sent, results);
        $display("noise results under 3 idling profiles, extreme register values and a hold-off.");
        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #40ms;
        $display("Timeout with %0d results still outstanding.", pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
